/* design/edt_pkg.sv */
`default_nettype none
package edt_pkg;

  localparam int SPLIT_STAGES = 7;
  localparam int CIVIL_STAGES = 6;
  localparam int TEXT_STAGES  = 2;
  localparam int STAGES       = SPLIT_STAGES + CIVIL_STAGES + TEXT_STAGES + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_ZONE = 1'b0,
    REG_YEAR = 1'b1
  } cfg_reg_t;

  localparam logic [32:0] SECS_PER_DAY  = 33'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [19:0] DAYS_TO_MARCH0 = 20'd719468;
  localparam logic [19:0] ERA4_START     = 20'd584388;
  localparam logic [19:0] ERA5_START     = 20'd730485;
  localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
  localparam logic [17:0] LAST_DOE       = 18'd146096;
  localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
  localparam logic [11:0] ERA4_YEAR      = 12'd1600;
  localparam logic [11:0] ERA5_YEAR      = 12'd2000;

  // Reciprocals for division by constants: quotient = (x * M) >> S.
  localparam int DIV675_S = 36;
  localparam logic [26:0] DIV675_M = 27'((64'd1 << DIV675_S) / 64'd675 + 64'd1);
  localparam int DIV225_S = 21;
  localparam logic [13:0] DIV225_M = 14'((64'd1 << DIV225_S) / 64'd225 + 64'd1);
  localparam int DIV15_S = 14;
  localparam logic [10:0] DIV15_M = 11'((64'd1 << DIV15_S) / 64'd15 + 64'd1);
  localparam int DIV365A_S = 25;
  localparam logic [16:0] DIV365A_M = 17'((64'd1 << DIV365A_S) / 64'd365 + 64'd1);
  localparam int DIV365B_S = 27;
  localparam logic [18:0] DIV365B_M = 19'((64'd1 << DIV365B_S) / 64'd365 + 64'd1);
  localparam int DIV100A_S = 16;
  localparam logic [9:0] DIV100A_M = 10'((64'd1 << DIV100A_S) / 64'd100 + 64'd1);
  localparam int DIV100B_S = 19;
  localparam logic [12:0] DIV100B_M = 13'((64'd1 << DIV100B_S) / 64'd100 + 64'd1);

  // First day of each month counted from March, as (153 * m + 2) / 5.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic signed [10:0] zone;
    logic [15:0]        cur_year;
  } cfg_t;

  typedef struct packed {
    logic        rej;
    logic [16:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } tsplit_t;

  typedef struct packed {
    logic        rej;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } civil_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] text_head;
    logic [31:0] text_tail;
    logic        shows_year;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } result_t;

  function automatic logic [23:0] month_abbr(input logic [3:0] mo);
    logic [23:0] s;
    case (mo)
      4'd1:    s = "Jan";
      4'd2:    s = "Feb";
      4'd3:    s = "Mar";
      4'd4:    s = "Apr";
      4'd5:    s = "May";
      4'd6:    s = "Jun";
      4'd7:    s = "Jul";
      4'd8:    s = "Aug";
      4'd9:    s = "Sep";
      4'd10:   s = "Oct";
      4'd11:   s = "Nov";
      4'd12:   s = "Dec";
      default: s = 24'h0;
    endcase
    return s;
  endfunction

  // Two ASCII digits of a value below one hundred.
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [3:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    ones = 4'(v - ({3'b0, tens} << 3) - ({3'b0, tens} << 1));
    return {ASCII_DIGIT_HI, tens, ASCII_DIGIT_HI, ones};
  endfunction

endpackage
`default_nettype wire

/* design/edt_cfg_regs.sv */
`default_nettype none
module edt_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [edt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [edt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [edt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output edt_pkg::cfg_t                         cfg
);

  edt_pkg::cfg_t    cfg_r;
  edt_pkg::cfg_reg_t reg_sel;
  logic             wr_en;

  assign reg_sel = edt_pkg::cfg_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone     <= '0;
      cfg_r.cur_year <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        edt_pkg::REG_ZONE: cfg_r.zone     <= $signed(pwdata[10:0]);
        edt_pkg::REG_YEAR: cfg_r.cur_year <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      edt_pkg::REG_ZONE: prdata = {21'b0, $unsigned(cfg_r.zone)};
      edt_pkg::REG_YEAR: prdata = {16'b0, cfg_r.cur_year};
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* design/edt_time_split.sv */
`default_nettype none
module edt_time_split (
  input  wire logic                             clk,
  input  wire logic [edt_pkg::SPLIT_STAGES-1:0] load,
  input  wire logic [63:0]                      timestamp,
  input  wire logic signed [10:0]               zone,
  output edt_pkg::tsplit_t                      res
);

  logic [63:0] ts_r;

  logic        off_neg;
  logic [10:0] off_mag;
  logic [16:0] off_secs;
  logic        rej1_nxt;
  logic [32:0] secs1_nxt;
  logic        rej1_r;
  logic [32:0] secs1_r;

  logic [52:0] days_prod;
  logic        rej2_r;
  logic [32:0] secs2_r;
  logic [16:0] days2_r;

  logic [32:0] rem_full;
  logic        rej3_r;
  logic [16:0] days3_r;
  logic [16:0] rem3_r;

  logic [26:0] hr_prod;
  logic        rej4_r;
  logic [16:0] days4_r;
  logic [16:0] rem4_r;
  logic [4:0]  hr4_r;

  logic [16:0] rem_min;
  logic        rej5_r;
  logic [16:0] days5_r;
  logic [4:0]  hr5_r;
  logic [11:0] rem5_r;

  logic [20:0]      mn_prod;
  edt_pkg::tsplit_t res_nxt;
  edt_pkg::tsplit_t res_r;

  always_comb begin
    off_neg   = zone[10];
    off_mag   = off_neg ? (~$unsigned(zone) + 11'd1) : $unsigned(zone);
    off_secs  = 17'(off_mag) * edt_pkg::SECS_PER_MIN;
    rej1_nxt  = (|ts_r[63:32]) || (ts_r == 64'd0) ||
                (off_neg && ({1'b0, ts_r[31:0]} < {16'b0, off_secs}));
    secs1_nxt = off_neg ? ({1'b0, ts_r[31:0]} - {16'b0, off_secs})
                        : ({1'b0, ts_r[31:0]} + {16'b0, off_secs});
  end

  assign days_prod = 53'(secs1_r[32:7]) * 53'(edt_pkg::DIV675_M);
  assign rem_full  = secs2_r - (33'(days2_r) * edt_pkg::SECS_PER_DAY);
  assign hr_prod   = 27'(rem3_r[16:4]) * 27'(edt_pkg::DIV225_M);
  assign rem_min   = rem4_r - (17'(hr4_r) * edt_pkg::SECS_PER_HOUR);
  assign mn_prod   = 21'(rem5_r[11:2]) * 21'(edt_pkg::DIV15_M);

  always_comb begin
    res_nxt.rej    = rej5_r;
    res_nxt.days   = days5_r;
    res_nxt.hour   = hr5_r;
    res_nxt.minute = mn_prod[19:14];
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      ts_r <= timestamp;
    end
    if (load[1]) begin
      rej1_r  <= rej1_nxt;
      secs1_r <= secs1_nxt;
    end
    if (load[2]) begin
      rej2_r  <= rej1_r;
      secs2_r <= secs1_r;
      days2_r <= days_prod[52:36];
    end
    if (load[3]) begin
      rej3_r  <= rej2_r;
      days3_r <= days2_r;
      rem3_r  <= rem_full[16:0];
    end
    if (load[4]) begin
      rej4_r  <= rej3_r;
      days4_r <= days3_r;
      rem4_r  <= rem3_r;
      hr4_r   <= hr_prod[25:21];
    end
    if (load[5]) begin
      rej5_r  <= rej4_r;
      days5_r <= days4_r;
      hr5_r   <= hr4_r;
      rem5_r  <= rem_min[11:0];
    end
    if (load[6]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

/* design/edt_civil.sv */
`default_nettype none
module edt_civil (
  input  wire logic                             clk,
  input  wire logic [edt_pkg::CIVIL_STAGES-1:0] load,
  input  wire edt_pkg::tsplit_t                 tsp,
  output edt_pkg::civil_t                       res
);

  logic [19:0] z;
  logic        era_hi;
  logic [19:0] doe_full;

  edt_pkg::tsplit_t t7_r, t8_r, t9_r, t10_r, t11_r;
  logic        era7_r, era8_r, era9_r, era10_r, era11_r;
  logic [17:0] doe7_r, doe8_r, doe9_r, doe10_r;

  logic [32:0] c1_prod;
  logic [2:0]  c2;
  logic        c3;
  logic [17:0] tsum_nxt;
  logic [17:0] tsum8_r;

  logic [36:0] yoe_prod;
  logic [8:0]  yoe9_r, yoe10_r, yoe11_r;

  logic [18:0] y100_prod;
  logic [2:0]  y100_10_r;

  logic [17:0] doy_full;
  logic [8:0]  doy11_r;

  logic [3:0]      mp;
  logic [8:0]      day_full;
  edt_pkg::civil_t res_nxt;
  edt_pkg::civil_t res_r;

  always_comb begin
    z        = 20'(tsp.days) + edt_pkg::DAYS_TO_MARCH0;
    era_hi   = z >= edt_pkg::ERA5_START;
    doe_full = z - (era_hi ? edt_pkg::ERA5_START : edt_pkg::ERA4_START);
  end

  always_comb begin
    c1_prod  = 33'(doe7_r[17:2]) * 33'(edt_pkg::DIV365A_M);
    c2       = 3'(doe7_r >= edt_pkg::DAYS_PER_100Y) +
               3'(doe7_r >= 18'(2 * 36524)) +
               3'(doe7_r >= 18'(3 * 36524)) +
               3'(doe7_r >= edt_pkg::LAST_DOE);
    c3       = doe7_r == edt_pkg::LAST_DOE;
    tsum_nxt = doe7_r - 18'(c1_prod[31:25]) + 18'(c2) - 18'(c3);
  end

  assign yoe_prod  = 37'(tsum8_r) * 37'(edt_pkg::DIV365B_M);
  assign y100_prod = 19'(yoe9_r) * 19'(edt_pkg::DIV100A_M);
  assign doy_full  = doe10_r - ((18'(yoe10_r) * edt_pkg::DAYS_PER_YEAR) +
                                18'(yoe10_r[8:2]) - 18'(y100_10_r));

  always_comb begin
    mp = '0;
    for (int m = 1; m < 12; m++) begin
      mp = mp + 4'(doy11_r >= edt_pkg::MONTH_START[m]);
    end
    day_full       = doy11_r - edt_pkg::MONTH_START[mp] + 9'd1;
    res_nxt.rej    = t11_r.rej;
    res_nxt.hour   = t11_r.hour;
    res_nxt.minute = t11_r.minute;
    res_nxt.day    = day_full[4:0];
    res_nxt.month  = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
    res_nxt.year   = 12'(yoe11_r) + (era11_r ? edt_pkg::ERA5_YEAR : edt_pkg::ERA4_YEAR) +
                     12'(mp >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      t7_r   <= tsp;
      era7_r <= era_hi;
      doe7_r <= doe_full[17:0];
    end
    if (load[1]) begin
      t8_r    <= t7_r;
      era8_r  <= era7_r;
      doe8_r  <= doe7_r;
      tsum8_r <= tsum_nxt;
    end
    if (load[2]) begin
      t9_r   <= t8_r;
      era9_r <= era8_r;
      doe9_r <= doe8_r;
      yoe9_r <= yoe_prod[35:27];
    end
    if (load[3]) begin
      t10_r     <= t9_r;
      era10_r   <= era9_r;
      doe10_r   <= doe9_r;
      yoe10_r   <= yoe9_r;
      y100_10_r <= y100_prod[18:16];
    end
    if (load[4]) begin
      t11_r   <= t10_r;
      era11_r <= era10_r;
      yoe11_r <= yoe10_r;
      doy11_r <= doy_full[8:0];
    end
    if (load[5]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

/* design/edt_text.sv */
`default_nettype none
module edt_text (
  input  wire logic                            clk,
  input  wire logic [edt_pkg::TEXT_STAGES-1:0] load,
  input  wire edt_pkg::civil_t                 civ,
  input  wire logic [15:0]                     cur_year,
  output edt_pkg::result_t                     res
);

  logic [24:0]     cent_prod;
  edt_pkg::civil_t civ13_r, civ14_r;
  logic [5:0]      cent13_r, cent14_r;
  logic [11:0]     ylo_full;
  logic [6:0]      ylo14_r;

  logic [15:0] day2, hr2, mn2, cent2, ylo2;
  logic        year_form;
  logic [63:0] head;
  logic [31:0] tail;

  assign cent_prod = 25'(civ.year) * 25'(edt_pkg::DIV100B_M);
  assign ylo_full  = civ13_r.year - (12'(cent13_r) * 12'd100);

  always_comb begin
    day2      = edt_pkg::two_digits(7'(civ14_r.day));
    hr2       = edt_pkg::two_digits(7'(civ14_r.hour));
    mn2       = edt_pkg::two_digits(7'(civ14_r.minute));
    cent2     = edt_pkg::two_digits(7'(cent14_r));
    ylo2      = edt_pkg::two_digits(ylo14_r);
    year_form = (cur_year != 16'd0) && (16'(civ14_r.year) != cur_year);
    head      = {edt_pkg::month_abbr(civ14_r.month), edt_pkg::ASCII_SPACE, day2,
                 edt_pkg::ASCII_SPACE, year_form ? edt_pkg::ASCII_SPACE : hr2[15:8]};
    tail      = year_form ? {cent2, ylo2} : {hr2[7:0], edt_pkg::ASCII_COLON, mn2};
    if (civ14_r.rej) begin
      res = '0;
    end else begin
      res.valid_res  = 1'b1;
      res.text_head  = head;
      res.text_tail  = tail;
      res.shows_year = year_form;
      res.year       = civ14_r.year;
      res.month      = civ14_r.month;
      res.day        = civ14_r.day;
      res.hour       = civ14_r.hour;
      res.minute     = civ14_r.minute;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      civ13_r  <= civ;
      cent13_r <= cent_prod[24:19];
    end
    if (load[1]) begin
      civ14_r  <= civ13_r;
      cent14_r <= cent13_r;
      ylo14_r  <= ylo_full[6:0];
    end
  end

endmodule
`default_nettype wire

/* design/epoch_seconds_to_date_text_unit.sv */
`default_nettype none
// Converts a Unix timestamp in seconds into a twelve-character local date label,
// "Mon DD HH:MM" when the date falls in the configured current year (or that year
// is zero) and "Mon DD  YYYY" otherwise, together with the decoded year, month,
// day, hour and minute. Timestamps with any of the upper 32 bits set, a zero
// timestamp, or one that a negative zone offset would carry before the epoch give
// a result with valid_res clear and every other field zero. The block takes a new
// request every clock cycle while in_stall is low. The pipeline is built around
// the chain of constant-reciprocal multiplications (days, hours, minutes,
// leap-day correction, year of era, centuries, century digits), each of which is
// followed by a pipeline register. Stages holding no request close up while the
// output is stalled, so requests keep being taken until the pipeline is full.
module epoch_seconds_to_date_text_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [63:0]                    in_timestamp,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_valid_res,
  output logic      [63:0]                    out_text_head,
  output logic      [31:0]                    out_text_tail,
  output logic                                out_shows_year,
  output logic      [11:0]                    out_year,
  output logic      [3:0]                     out_month,
  output logic      [4:0]                     out_day,
  output logic      [4:0]                     out_hour,
  output logic      [5:0]                     out_minute,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [edt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [edt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [edt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int CivilLo = edt_pkg::SPLIT_STAGES;
  localparam int TextLo  = CivilLo + edt_pkg::CIVIL_STAGES;
  localparam int OutIdx  = edt_pkg::STAGES - 1;

  edt_pkg::cfg_t              cfg;
  edt_pkg::tsplit_t           tsp;
  edt_pkg::civil_t            civ;
  edt_pkg::result_t           res_nxt;
  edt_pkg::result_t           res_r;
  logic [edt_pkg::STAGES-1:0] v_r;
  logic [edt_pkg::STAGES-1:0] load;

  edt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  edt_time_split u_split (
    .clk       (clk),
    .load      (load[CivilLo-1:0]),
    .timestamp (in_timestamp),
    .zone      (cfg.zone),
    .res       (tsp)
  );

  edt_civil u_civil (
    .clk  (clk),
    .load (load[TextLo-1:CivilLo]),
    .tsp  (tsp),
    .res  (civ)
  );

  edt_text u_text (
    .clk      (clk),
    .load     (load[OutIdx-1:TextLo]),
    .civ      (civ),
    .cur_year (cfg.cur_year),
    .res      (res_nxt)
  );

  // A stage may load when the output moves or it or some later stage is empty.
  for (genvar g = 0; g < edt_pkg::STAGES; g++) begin : g_load
    assign load[g] = !out_stall || !(&v_r[OutIdx:g]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < edt_pkg::STAGES; i++) begin
        if (load[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[OutIdx]) begin
      res_r <= res_nxt;
    end
  end

  assign in_stall       = !load[0];
  assign out_valid      = v_r[OutIdx];
  assign out_valid_res  = res_r.valid_res;
  assign out_text_head  = res_r.text_head;
  assign out_text_tail  = res_r.text_tail;
  assign out_shows_year = res_r.shows_year;
  assign out_year       = res_r.year;
  assign out_month      = res_r.month;
  assign out_day        = res_r.day;
  assign out_hour       = res_r.hour;
  assign out_minute     = res_r.minute;

endmodule
`default_nettype wire

/* design/edt_checker.sv */
`default_nettype none
module edt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_valid_res,
  input wire logic [63:0] out_text_head,
  input wire logic [31:0] out_text_tail,
  input wire logic        out_shows_year,
  input wire logic [11:0] out_year,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day,
  input wire logic [4:0]  out_hour,
  input wire logic [5:0]  out_minute,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_text_head) &&
      $stable(out_text_tail) && $stable(out_valid_res) && $stable(out_year))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_text_head == 64'd0 && out_text_tail == 32'd0 &&
      !out_shows_year && out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0 &&
      out_hour == 5'd0 && out_minute == 6'd0)
    else $error("rejected request gave non-zero fields");

  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day >= 5'd1 && out_hour <= 5'd23 && out_minute <= 6'd59)
    else $error("decoded date out of range");

  a_time_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res && !out_shows_year |->
      out_text_tail[23:16] == edt_pkg::ASCII_COLON)
    else $error("time form without colon");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind epoch_seconds_to_date_text_unit edt_checker u_edt_checker (.*);
`default_nettype wire
